// ===== design/bmp_rle_pkg.sv =====
// Shared types and constants for the bitmap RLE8/RLE4 pixel decoder.
// Holds the channel beat structs, action codes and palette geometry.
// No dependencies.
package bmp_rle_pkg;

  // Palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  // Output coordinate width and saturation value
  localparam int COORD_BITS = 12;
  localparam logic [12:0] COORD_MAX = 13'((1 << COORD_BITS) - 1);

  // Internal position limits
  localparam logic [12:0] COL_MAX = 13'd8191;
  localparam logic signed [13:0] ROW_MIN = -14'sd8192;

  // Color constants
  localparam logic [31:0] WHITE = 32'h00ff_ffff;
  localparam logic [3:0] NIBBLE = 4'd15;

  // Register reset values
  localparam logic [12:0] WIDTH_RESET = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes
  localparam logic [1:0] REG_DEPTH_MODE = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Input actions
  localparam logic [1:0] ACT_PALETTE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_BYTE = 2'd2;

  // Result kinds
  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_END = 1'b1;

  // Stream escape codes
  localparam logic [7:0] ESC_EOL = 8'd0;
  localparam logic [7:0] ESC_EOB = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  palette_index;
    logic [31:0] palette_color;
    logic [7:0]  data_byte;
  } bmp_rle_in_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] span_x;
    logic [11:0] span_y;
    logic [7:0]  span_length;
    logic [31:0] even_color;
    logic [31:0] odd_color;
    logic        outside;
  } bmp_rle_out_t;

  // Decoder phase, one-hot
  typedef enum logic [7:0] {
    PH_DONE  = 8'b0000_0001,
    PH_COUNT = 8'b0000_0010,
    PH_RUN   = 8'b0000_0100,
    PH_ESC   = 8'b0000_1000,
    PH_DX    = 8'b0001_0000,
    PH_DY    = 8'b0010_0000,
    PH_ABS   = 8'b0100_0000,
    PH_PAD   = 8'b1000_0000
  } phase_t;

  // Palette contents after reset for an entry never written
  function automatic logic [31:0] pal_default(input logic [PAL_AW-1:0] addr);
    logic hit;
    hit = (addr == PAL_AW'(1));
    if (PALETTE_ENTRIES > 255 && addr == PAL_AW'(255 % PALETTE_ENTRIES)) begin
      hit = 1'b1;
    end
    return hit ? WHITE : 32'd0;
  endfunction

endpackage

// ===== design/bmp_rle_pixel_decoder.sv =====
// Bitmap RLE8/RLE4 pixel decoder top level.
// Uses bmp_rle_pkg for beat structs, codes and palette constants.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one beat per item:
//   a palette write, an image start, or one compressed stream byte.
//   Output channel (out_valid/out_stall/out_data) carries pixel spans and
//   the end-of-bitmap marker. Each beat yields zero or one result.
//   Config port (cfg_write/cfg_index/cfg_data) sets depth mode, width and
//   height; write it only while the decoder is idle.
// Timing:
//   One input beat per cycle sustained while in_stall is low. A taken beat's
//   result passes through the synchronous palette read (two read ports, one
//   per nibble) and then the output register before it shows on out_valid.
//   Palette writes take one beat and are visible to the next beat.
// Reset:
//   Synchronous rst clears control state and palette valid bits; unwritten
//   entries read as 0, except entries 1 and 255 which read as white. The
//   decoder ignores stream bytes until a start beat.
// Stall:
//   When out_stall holds a pending result, the palette stage fills and then
//   in_stall rises; no beat is lost or repeated.
module bmp_rle_pixel_decoder
  import bmp_rle_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  bmp_rle_in_t  in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output bmp_rle_out_t out_data,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  // Configuration registers
  logic        depth_mode;
  logic [12:0] image_width;
  logic [12:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode   <= 1'b0;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEPTH_MODE: depth_mode   <= cfg_data[0];
        REG_WIDTH:      image_width  <= cfg_data;
        REG_HEIGHT:     image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decoder state
  phase_t             phase, phase_next;
  logic [7:0]         held_count, held_count_next;
  logic [7:0]         absolute_left, absolute_left_next;
  logic               pad_pending, pad_pending_next;
  logic [7:0]         delta_dx, delta_dx_next;
  logic [12:0]        column, column_next;
  logic signed [13:0] row, row_next;

  // Palette stage registers
  logic               s1_valid;
  logic               s1_kind;
  logic [11:0]        s1_x;
  logic [11:0]        s1_y;
  logic [7:0]         s1_len;
  logic               s1_outside;
  logic               s1_mode;

  // Handshake
  logic in_fire;
  logic s1_adv;
  logic emit;
  logic emit_fire;

  assign s1_adv    = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_adv;
  assign in_fire   = in_valid && !in_stall;
  assign emit_fire = in_fire && emit;

  // Span helpers
  logic [7:0]  span_len;
  logic [13:0] span_end;
  logic        span_outside;
  logic [11:0] span_x;
  logic [11:0] span_y;
  logic        emit_end;
  logic [13:0] dx_sum;
  logic signed [14:0] dy_diff;
  logic [8:0]  abs_plus;
  logic [7:0]  byte_in;

  assign byte_in  = in_data.data_byte;
  assign span_end = {1'b0, column} + {6'b0, span_len};
  assign span_outside = row[13] || (span_end > {1'b0, image_width});
  assign span_x = (column > COORD_MAX) ? COORD_MAX[11:0] : column[11:0];
  assign span_y = row[13] ? 12'd0 :
                  ({1'b0, row[12:0]} > {1'b0, COORD_MAX}) ? COORD_MAX[11:0] : row[11:0];
  assign dx_sum   = {1'b0, column} + {6'b0, delta_dx};
  assign dy_diff  = {row[13], row} - {7'b0, byte_in};
  assign abs_plus = {1'b0, byte_in} + 9'd1;

  // Next-state decode for one accepted beat
  always_comb begin
    phase_next         = phase;
    held_count_next    = held_count;
    absolute_left_next = absolute_left;
    pad_pending_next   = pad_pending;
    delta_dx_next      = delta_dx;
    column_next        = column;
    row_next           = row;
    emit               = 1'b0;
    emit_end           = 1'b0;
    span_len           = held_count;

    if (in_data.action == ACT_START) begin
      column_next        = 13'd0;
      row_next           = 14'({1'b0, image_height} - 14'd1);
      phase_next         = PH_COUNT;
      held_count_next    = 8'd0;
      absolute_left_next = 8'd0;
      pad_pending_next   = 1'b0;
      delta_dx_next      = 8'd0;
    end else if (in_data.action == ACT_BYTE) begin
      unique case (phase)
        PH_COUNT: begin
          if (byte_in != 8'd0) begin
            held_count_next = byte_in;
            phase_next      = PH_RUN;
          end else begin
            phase_next = PH_ESC;
          end
        end
        PH_RUN: begin
          span_len    = held_count;
          emit        = 1'b1;
          phase_next  = PH_COUNT;
          column_next = span_end[13] ? COL_MAX : span_end[12:0];
        end
        PH_ESC: begin
          case (byte_in)
            ESC_EOL: begin
              column_next = 13'd0;
              row_next    = (row != ROW_MIN) ? row - 14'sd1 : ROW_MIN;
              phase_next  = PH_COUNT;
            end
            ESC_EOB: begin
              phase_next = PH_DONE;
              emit       = 1'b1;
              emit_end   = 1'b1;
            end
            ESC_DELTA: phase_next = PH_DX;
            default: begin
              absolute_left_next = byte_in;
              pad_pending_next   = depth_mode ? abs_plus[1] : byte_in[0];
              phase_next         = PH_ABS;
            end
          endcase
        end
        PH_DX: begin
          delta_dx_next = byte_in;
          phase_next    = PH_DY;
        end
        PH_DY: begin
          column_next = dx_sum[13] ? COL_MAX : dx_sum[12:0];
          row_next    = (dy_diff < 15'(ROW_MIN)) ? ROW_MIN : dy_diff[13:0];
          phase_next  = PH_COUNT;
        end
        PH_ABS: begin
          span_len = (depth_mode && absolute_left >= 8'd2) ? 8'd2 : 8'd1;
          emit     = 1'b1;
          absolute_left_next = absolute_left - span_len;
          if (absolute_left_next == 8'd0) begin
            phase_next = pad_pending ? PH_PAD : PH_COUNT;
          end
          column_next = span_end[13] ? COL_MAX : span_end[12:0];
        end
        PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = PH_COUNT;
        end
        PH_DONE: ;
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      held_count    <= 8'd0;
      absolute_left <= 8'd0;
      pad_pending   <= 1'b0;
      delta_dx      <= 8'd0;
      column        <= 13'd0;
      row           <= 14'sd0;
    end else if (in_fire) begin
      phase         <= phase_next;
      held_count    <= held_count_next;
      absolute_left <= absolute_left_next;
      pad_pending   <= pad_pending_next;
      delta_dx      <= delta_dx_next;
      column        <= column_next;
      row           <= row_next;
    end
  end

  // Palette memory: one write port, two registered read ports
  logic [31:0]       palette [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_valid;
  logic [PAL_AW-1:0] wr_addr;
  logic              wr_ok;
  logic              wr_en;
  logic [PAL_AW-1:0] ra_addr, rb_addr;
  logic              ra_ok;
  logic [31:0]       ra_data, rb_data;
  logic              ra_valid, rb_valid;
  logic [PAL_AW-1:0] ra_addr_q, rb_addr_q;
  logic              ra_ok_q;
  logic [7:0]        ra_byte;

  assign wr_ok   = {1'b0, in_data.palette_index} < 9'(PALETTE_ENTRIES);
  assign wr_addr = in_data.palette_index[PAL_AW-1:0];
  assign wr_en   = in_fire && (in_data.action == ACT_PALETTE) && wr_ok;
  assign ra_byte = depth_mode ? {4'd0, byte_in[7:4] & NIBBLE} : byte_in;
  assign ra_ok   = {1'b0, ra_byte} < 9'(PALETTE_ENTRIES);
  assign ra_addr = ra_byte[PAL_AW-1:0];
  assign rb_addr = PAL_AW'(byte_in[3:0] & NIBBLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[wr_addr] <= in_data.palette_color;
    end
    if (emit_fire) begin
      ra_data   <= palette[ra_addr];
      rb_data   <= palette[rb_addr];
      ra_valid  <= pal_valid[ra_addr];
      rb_valid  <= pal_valid[rb_addr];
      ra_addr_q <= ra_addr;
      rb_addr_q <= rb_addr;
      ra_ok_q   <= ra_ok;
    end
  end

  // Written-entry flags; an unwritten entry reads its reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= '0;
    end else if (wr_en) begin
      pal_valid[wr_addr] <= 1'b1;
    end
  end

  // Palette stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= emit_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      s1_kind    <= emit_end ? KIND_END : KIND_SPAN;
      s1_x       <= emit_end ? 12'd0 : span_x;
      s1_y       <= emit_end ? 12'd0 : span_y;
      s1_len     <= emit_end ? 8'd0 : span_len;
      s1_outside <= emit_end ? 1'b0 : span_outside;
      s1_mode    <= depth_mode;
    end
  end

  // Color resolve
  logic [31:0] color_a, color_b;
  logic [31:0] even_c, odd_c;

  always_comb begin
    color_a = !ra_ok_q ? 32'd0 : (ra_valid ? ra_data : pal_default(ra_addr_q));
    color_b = rb_valid ? rb_data : pal_default(rb_addr_q);
    if (s1_kind == KIND_END) begin
      even_c = 32'd0;
      odd_c  = 32'd0;
    end else begin
      even_c = color_a;
      odd_c  = s1_mode ? color_b : color_a;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      out_data.kind        <= s1_kind;
      out_data.span_x      <= s1_x;
      out_data.span_y      <= s1_y;
      out_data.span_length <= s1_len;
      out_data.even_color  <= even_c;
      out_data.odd_color   <= odd_c;
      out_data.outside     <= s1_outside;
    end
  end

endmodule

// ===== tb/bmp_rle_checker.sv =====
// Scoreboard for the bitmap RLE8/RLE4 pixel decoder: tracks config writes and
// input beats, predicts every span and end marker, and compares output beats.
// Depends on bmp_rle_pkg for beat structs, codes and phase encoding.
module bmp_rle_checker
  import bmp_rle_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_stall,
  input  bmp_rle_in_t  in_data,
  input  logic         out_valid,
  input  logic         out_stall,
  input  bmp_rle_out_t out_data,
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data,
  output int           errors,
  output int           waiting,
  output int           spans_seen,
  output int           ends_seen
);

  // Shadow copy of the decoder state and its registers
  logic [31:0]        pal_words [PALETTE_ENTRIES];
  phase_t             ph;
  logic [7:0]         run_len;
  logic [7:0]         lit_left;
  logic               pad_due;
  logic [7:0]         step_x;
  logic [12:0]        col;
  logic signed [13:0] cur_row;
  logic               nibble_mode;
  logic [12:0]        width_reg;
  logic [12:0]        height_reg;

  // Expected result beats, oldest first
  bmp_rle_out_t spans_due [$];

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 30) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  // Colors for one stream byte: two nibble lookups in RLE4, one in RLE8
  function automatic void palette_pair(input logic [7:0] b, output logic [31:0] ev,
                                       output logic [31:0] od);
    if (nibble_mode) begin
      ev = pal_words[b[7:4]];
      od = pal_words[b[3:0]];
    end else begin
      ev = pal_words[b];
      od = ev;
    end
  endfunction

  // Span at the current position; column advances and saturates
  task automatic queue_span(input logic [7:0] len, input logic [31:0] ev,
                            input logic [31:0] od);
    bmp_rle_out_t s;
    int reach;
    s = '0;
    s.kind = KIND_SPAN;
    s.span_x = (col > COORD_MAX) ? 12'(COORD_MAX) : col[11:0];
    if (cur_row < 0) begin
      s.span_y = '0;
      s.outside = 1'b1;
    end else if (int'(cur_row) > int'(COORD_MAX)) begin
      s.span_y = 12'(COORD_MAX);
    end else begin
      s.span_y = cur_row[11:0];
    end
    reach = int'(col) + int'(len);
    if (reach > int'(width_reg)) begin
      s.outside = 1'b1;
    end
    s.span_length = len;
    s.even_color = ev;
    s.odd_color = od;
    col = (reach > int'(COL_MAX)) ? COL_MAX : 13'(reach);
    spans_due.push_back(s);
  endtask

  // Advance the shadow decoder by one accepted input beat
  task automatic decode_beat(input bmp_rle_in_t beat);
    logic [7:0]   b;
    logic [7:0]   len;
    logic [31:0]  ev;
    logic [31:0]  od;
    int           nxt;
    bmp_rle_out_t end_beat;
    b = beat.data_byte;
    case (beat.action)
      ACT_PALETTE: begin
        pal_words[beat.palette_index] = beat.palette_color;
      end
      ACT_START: begin
        col = '0;
        cur_row = 14'(int'(height_reg) - 1);
        ph = PH_COUNT;
        run_len = '0;
        lit_left = '0;
        pad_due = 1'b0;
        step_x = '0;
      end
      ACT_BYTE: begin
        case (ph)
          PH_COUNT: begin
            if (b != 8'd0) begin
              run_len = b;
              ph = PH_RUN;
            end else begin
              ph = PH_ESC;
            end
          end
          PH_RUN: begin
            palette_pair(b, ev, od);
            ph = PH_COUNT;
            queue_span(run_len, ev, od);
          end
          PH_ESC: begin
            case (b)
              ESC_EOL: begin
                col = '0;
                cur_row = (cur_row > ROW_MIN) ? cur_row - 14'sd1 : ROW_MIN;
                ph = PH_COUNT;
              end
              ESC_EOB: begin
                end_beat = '0;
                end_beat.kind = KIND_END;
                spans_due.push_back(end_beat);
                ph = PH_DONE;
              end
              ESC_DELTA: begin
                ph = PH_DX;
              end
              default: begin
                // absolute run; pad keeps the run word aligned
                lit_left = b;
                pad_due = nibble_mode ? (((int'(b) + 1) / 2) % 2 == 1) : b[0];
                ph = PH_ABS;
              end
            endcase
          end
          PH_DX: begin
            step_x = b;
            ph = PH_DY;
          end
          PH_DY: begin
            nxt = int'(col) + int'(step_x);
            col = (nxt > int'(COL_MAX)) ? COL_MAX : 13'(nxt);
            nxt = int'(cur_row) - int'(b);
            cur_row = (nxt < int'(ROW_MIN)) ? ROW_MIN : 14'(nxt);
            ph = PH_COUNT;
          end
          PH_ABS: begin
            len = (nibble_mode && lit_left >= 8'd2) ? 8'd2 : 8'd1;
            palette_pair(b, ev, od);
            lit_left = lit_left - len;
            if (lit_left == 8'd0) begin
              ph = pad_due ? PH_PAD : PH_COUNT;
            end
            queue_span(len, ev, od);
          end
          PH_PAD: begin
            pad_due = 1'b0;
            ph = PH_COUNT;
          end
          default: begin
            // done: bytes are dropped until the next start
          end
        endcase
      end
      default: begin
      end
    endcase
  endtask

  // Compare first, then apply config and input taken at the same edge
  always @(posedge clk) begin : track
    bmp_rle_out_t want;
    if (rst) begin
      foreach (pal_words[i]) begin
        pal_words[i] = '0;
      end
      pal_words[1] = WHITE;
      pal_words[255] = WHITE;
      ph = PH_DONE;
      run_len = '0;
      lit_left = '0;
      pad_due = 1'b0;
      step_x = '0;
      col = '0;
      cur_row = '0;
      nibble_mode = 1'b0;
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      spans_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (out_data.kind == KIND_END) begin
          ends_seen++;
        end else begin
          spans_seen++;
        end
        if (spans_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = spans_due.pop_front();
          check_field("kind", 32'(out_data.kind), 32'(want.kind));
          check_field("span_x", 32'(out_data.span_x), 32'(want.span_x));
          check_field("span_y", 32'(out_data.span_y), 32'(want.span_y));
          check_field("span_length", 32'(out_data.span_length), 32'(want.span_length));
          check_field("even_color", out_data.even_color, want.even_color);
          check_field("odd_color", out_data.odd_color, want.odd_color);
          check_field("outside", 32'(out_data.outside), 32'(want.outside));
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_DEPTH_MODE: nibble_mode = cfg_data[0];
          REG_WIDTH:      width_reg = cfg_data;
          REG_HEIGHT:     height_reg = cfg_data;
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        decode_beat(in_data);
      end
    end
    waiting = spans_due.size();
  end

endmodule

// ===== tb/bmp_rle_pixel_decoder_test.sv =====
// Top-level bench for the bitmap RLE8/RLE4 pixel decoder: drives directed and
// random compressed streams under bursty input and stalling output.
// Depends on bmp_rle_pkg, bmp_rle_pixel_decoder and bmp_rle_checker.
module bmp_rle_pixel_decoder_test;
  import bmp_rle_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int BEATS_PER_PHASE = 90;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic         clk;
  logic         rst;
  logic         in_valid;
  logic         in_stall;
  bmp_rle_in_t  in_data;
  logic         out_valid;
  logic         out_stall;
  bmp_rle_out_t out_data;
  logic         cfg_write;
  logic [1:0]   cfg_index;
  logic [12:0]  cfg_data;

  int errors;
  int waiting;
  int spans_seen;
  int ends_seen;

  // Sender and receiver controls; each has a single writer
  rx_mode_t rx_mode = RX_OPEN;
  int       hold_ticket = 0;
  int       burst_left;
  int       gap_max;
  int       stream_beats;
  logic     nibble_mode;

  bmp_rle_pixel_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bmp_rle_checker watch (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .waiting    (waiting),
    .spans_seen (spans_seen),
    .ends_seen  (ends_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL bmp_rle_pixel_decoder");
    $finish;
  end

  // Output side: stall pattern per mode, plus long hold-offs on request
  initial begin : receiver
    int served;
    int hold_left;
    int tick;
    served = 0;
    hold_left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_ticket != served) begin
        served = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_stall = 1'b0;
          RX_LIGHT:  out_stall = ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall = ($urandom_range(0, 9) < 7);
          default:   out_stall = ((tick % 7) < 3);
        endcase
      end
    end
  end

  function automatic bmp_rle_in_t beat_of(input logic [1:0] act, input logic [7:0] b);
    bmp_rle_in_t t;
    t.action = act;
    t.palette_index = 8'($urandom);
    t.palette_color = $urandom;
    t.data_byte = b;
    return t;
  endfunction

  // Offer one beat at a falling edge and hold it until taken; valid stays high
  task automatic send_beat(input bmp_rle_in_t beat);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max > 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
    end
    in_data = beat;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic stream_byte(input logic [7:0] b);
    send_beat(beat_of(ACT_BYTE, b));
    stream_beats++;
  endtask

  task automatic write_palette(input logic [7:0] idx, input logic [31:0] color);
    bmp_rle_in_t t;
    t = beat_of(ACT_PALETTE, 8'($urandom));
    t.palette_index = idx;
    t.palette_color = color;
    send_beat(t);
    stream_beats++;
  endtask

  task automatic start_image();
    send_beat(beat_of(ACT_START, 8'($urandom)));
  endtask

  // Stop offering, wait out every expected beat, then the pipeline depth
  task automatic drain();
    in_valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic mode, input logic [12:0] w, input logic [12:0] h);
    drain();
    cfg_write = 1'b1;
    cfg_index = REG_DEPTH_MODE;
    cfg_data = 13'(mode);
    @(negedge clk);
    cfg_index = REG_WIDTH;
    cfg_data = w;
    @(negedge clk);
    cfg_index = REG_HEIGHT;
    cfg_data = h;
    @(negedge clk);
    cfg_write = 1'b0;
    nibble_mode = mode;
  endtask

  // One image: mostly well-formed opcodes with random content, some noise
  task automatic random_image();
    int ops;
    int pick;
    int n;
    int bytes;
    start_image();
    ops = $urandom_range(3, 25);
    repeat (ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
        stream_byte(8'(n));
        stream_byte(8'($urandom));
      end else if (pick < 55) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 14);
        bytes = nibble_mode ? (n + 1) / 2 : n;
        stream_byte(ESC_EOL);
        stream_byte(8'(n));
        repeat (bytes) stream_byte(8'($urandom));
        if ((bytes % 2) == 1) begin
          stream_byte(8'($urandom));
        end
      end else if (pick < 65) begin
        stream_byte(ESC_EOL);
        stream_byte(ESC_EOL);
      end else if (pick < 75) begin
        stream_byte(ESC_EOL);
        stream_byte(ESC_DELTA);
        stream_byte(($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom_range(0, 20)));
        stream_byte(($urandom_range(0, 5) == 0) ? 8'hff : 8'($urandom_range(0, 3)));
      end else if (pick < 83) begin
        // low entries matter most for RLE4 nibble lookups
        n = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        write_palette(8'(n), $urandom);
      end else if (pick < 90) begin
        stream_byte(8'($urandom));
      end else if (pick < 94) begin
        send_beat(beat_of(ACT_UNUSED, 8'($urandom)));
      end else begin
        start_image();
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      stream_byte(ESC_EOL);
      stream_byte(ESC_EOB);
      if ($urandom_range(0, 3) == 0) begin
        send_beat(beat_of(ACT_BYTE, 8'($urandom)));
      end
    end
  endtask

  initial begin : stimulus
    int       mode_of [PHASES];
    int       width_of [PHASES];
    int       height_of [PHASES];
    rx_mode_t rx_of [PHASES];
    int       gap_of [PHASES];
    int       target;
    mode_of = '{1, 0, 1, 0, 1, 0};
    width_of = '{4096, 1, 0, 8191, 0, 640};
    height_of = '{4096, 1, 0, 8191, 0, 480};
    rx_of = '{RX_LIGHT, RX_OPEN, RX_HEAVY, RX_PERIODIC, RX_LIGHT, RX_OPEN};
    gap_of = '{4, 0, 6, 2, 0, 3};
    width_of[4] = $urandom_range(2, 700);
    height_of[4] = $urandom_range(2, 40);

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = REG_DEPTH_MODE;
    cfg_data = '0;
    burst_left = 0;
    gap_max = 3;
    stream_beats = 0;
    nibble_mode = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: ignored bytes, default palette, every escape, mid-run restart
    send_beat(beat_of(ACT_BYTE, 8'h00));
    send_beat(beat_of(ACT_UNUSED, 8'hff));
    start_image();
    stream_byte(8'hff);
    stream_byte(8'hff);
    stream_byte(8'h01);
    stream_byte(8'h01);
    write_palette(8'h00, 32'hffff_ffff);
    write_palette(8'hff, 32'h0000_0000);
    stream_byte(8'h02);
    stream_byte(8'h00);
    stream_byte(ESC_EOL);
    stream_byte(8'h03);
    stream_byte(8'hff);
    stream_byte(8'h00);
    stream_byte(8'h7e);
    stream_byte(8'h5a);
    stream_byte(ESC_EOL);
    stream_byte(ESC_DELTA);
    stream_byte(8'hff);
    stream_byte(8'hff);
    stream_byte(8'h04);
    stream_byte(8'h81);
    stream_byte(8'h09);
    start_image();
    stream_byte(ESC_EOL);
    stream_byte(ESC_EOB);
    stream_byte(8'h77);

    // Random phases, one register setting each
    target = stream_beats;
    for (int p = 0; p < PHASES; p++) begin
      configure(mode_of[p][0], 13'(width_of[p]), 13'(height_of[p]));
      rx_mode = rx_of[p];
      gap_max = gap_of[p];
      if (p == 1) begin
        // long output hold-off while input runs flat out
        hold_ticket++;
      end
      if (p == 2) begin
        // drive the row into saturation, then emit a span there
        start_image();
        repeat (34) begin
          stream_byte(ESC_EOL);
          stream_byte(ESC_DELTA);
          stream_byte(8'hff);
          stream_byte(8'hff);
        end
        stream_byte(8'h03);
        stream_byte(8'h21);
      end
      target += BEATS_PER_PHASE;
      while (stream_beats < target) begin
        random_image();
        if ($urandom_range(0, 5) == 0) begin
          drain();
        end
      end
    end

    drain();
    repeat (6) @(negedge clk);
    $display("Run drove %0d stream beats over %0d register settings, RLE8 and RLE4.",
             stream_beats, PHASES + 1);
    $display("Compared %0d pixel spans and %0d end-of-bitmap beats.", spans_seen, ends_seen);
    if (errors == 0 && waiting == 0) begin
      $display("PASS bmp_rle_pixel_decoder");
    end else begin
      $display("FAIL bmp_rle_pixel_decoder");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bmp_rle_pkg.sv
design/bmp_rle_pixel_decoder.sv
tb/bmp_rle_checker.sv
tb/bmp_rle_pixel_decoder_test.sv
